// File: rtl/core/rcl_pkg.sv
package rcl_pkg;

  // Character codes used by the parser
  localparam logic [7:0] ChrSpace = 8'd32;
  localparam logic [7:0] ChrTab   = 8'd9;
  localparam logic [7:0] ChrCr    = 8'd13;
  localparam logic [7:0] ChrZero  = 8'd48;
  localparam logic [7:0] ChrNine  = 8'd57;
  localparam logic [7:0] ChrUpA   = 8'd65;
  localparam logic [7:0] ChrUpZ   = 8'd90;
  localparam logic [7:0] ChrLowO  = 8'd111;
  localparam logic [7:0] ChrLowN  = 8'd110;
  localparam logic [7:0] ChrLowF  = 8'd102;

  localparam int unsigned ValueW = 5;

  // Digit run scanner state
  typedef enum logic [2:0] {
    SCAN_NONE = 3'b001,
    SCAN_RUN  = 3'b010,
    SCAN_DONE = 3'b100
  } scan_e;

  // Status word matcher state
  typedef enum logic [5:0] {
    WM_START = 6'b000001,
    WM_O     = 6'b000010,
    WM_ON    = 6'b000100,
    WM_OF    = 6'b001000,
    WM_OFF   = 6'b010000,
    WM_DEAD  = 6'b100000
  } match_e;

  typedef struct packed {
    logic [ValueW-1:0] value;
    scan_e             scan;
  } scan_t;

  // Result of one command line
  typedef struct packed {
    logic              command_ok;
    logic [ValueW-1:0] port_number;
    logic [ValueW-1:0] channel_number;
    logic              relay_on;
  } result_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == ChrSpace) || ((c >= ChrTab) && (c <= ChrCr));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= ChrZero) && (c <= ChrNine);
  endfunction

  // Advance a digit run by one non-blank byte, saturating at sat
  function automatic scan_t scan_step(scan_t cur, logic [7:0] c, logic [ValueW-1:0] sat);
    logic  dig;
    logic  [8:0] acc;
    scan_t nxt;
    dig = is_digit(c);
    acc = 9'({4'b0, cur.value} * 9'd10) + {5'b0, c[3:0]};
    nxt = cur;
    unique case (cur.scan)
      SCAN_NONE: begin
        if (dig) begin
          nxt.value = {1'b0, c[3:0]};
          nxt.scan  = SCAN_RUN;
        end
      end
      SCAN_RUN: begin
        if (dig) begin
          nxt.value = (acc > {4'b0, sat}) ? sat : acc[ValueW-1:0];
        end else begin
          nxt.scan = SCAN_DONE;
        end
      end
      SCAN_DONE: nxt = cur;
      default:   nxt = cur;
    endcase
    return nxt;
  endfunction

  // Advance the on/off matcher by one byte, case folded
  function automatic match_e match_step(match_e m, logic [7:0] c);
    logic [7:0] lc;
    match_e     nxt;
    lc = ((c >= ChrUpA) && (c <= ChrUpZ)) ? (c | 8'h20) : c;
    unique case (m)
      WM_START: nxt = (lc == ChrLowO) ? WM_O : WM_DEAD;
      WM_O:     nxt = (lc == ChrLowN) ? WM_ON : ((lc == ChrLowF) ? WM_OF : WM_DEAD);
      WM_OF:    nxt = (lc == ChrLowF) ? WM_OFF : WM_DEAD;
      default:  nxt = WM_DEAD;
    endcase
    return nxt;
  endfunction

endpackage

// File: rtl/core/rcl_if.sv
interface rcl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rcl_out_if;
  logic       valid;
  logic       ready;
  logic       command_ok;
  logic [4:0] port_number;
  logic [4:0] channel_number;
  logic       relay_on;

  modport source (output valid, output command_ok, output port_number,
                  output channel_number, output relay_on, input ready);
  modport sink (input valid, input command_ok, input port_number,
                input channel_number, input relay_on, output ready);
endinterface

// File: rtl/core/rcl_parse.sv
module rcl_parse
  import rcl_pkg::*;
#(
  parameter int unsigned MAX_INDEX = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic [7:0] data_byte_i,
  input  logic    last_byte_i,
  output result_t result_o
);

  localparam logic [ValueW-1:0] MaxVal = ValueW'(MAX_INDEX);
  localparam logic [ValueW-1:0] SatVal = ValueW'(MAX_INDEX + 1);

  logic [1:0] token_count_q, token_count_d;
  logic       inside_token_q, inside_token_d;
  scan_t      port_q, port_d;
  scan_t      channel_q, channel_d;
  match_e     word_match_q, word_match_d;
  match_e     match_base;
  logic       blank;

  // Update parse state for one byte
  always_comb begin
    blank          = is_blank(data_byte_i);
    token_count_d  = token_count_q;
    inside_token_d = inside_token_q;
    port_d         = port_q;
    channel_d      = channel_q;
    word_match_d   = word_match_q;
    match_base     = word_match_q;
    if (blank) begin
      inside_token_d = 1'b0;
      if (port_q.scan == SCAN_RUN) port_d.scan = SCAN_DONE;
      if (channel_q.scan == SCAN_RUN) channel_d.scan = SCAN_DONE;
    end else begin
      if (!inside_token_q) begin
        inside_token_d = 1'b1;
        if (token_count_q != 2'd3) token_count_d = token_count_q + 2'd1;
        match_base = WM_START;
      end
      if (token_count_d == 2'd1) begin
        port_d = scan_step(port_q, data_byte_i, SatVal);
      end else begin
        channel_d = scan_step(channel_q, data_byte_i, SatVal);
      end
      word_match_d = match_step(match_base, data_byte_i);
    end
  end

  // Judge the line from the updated state
  always_comb begin
    logic ok;
    ok = (token_count_d == 2'd3)
      && (port_d.value >= ValueW'(1)) && (port_d.value <= MaxVal)
      && (channel_d.value >= ValueW'(1)) && (channel_d.value <= MaxVal)
      && ((word_match_d == WM_ON) || (word_match_d == WM_OFF));
    result_o.command_ok     = ok;
    result_o.port_number    = ok ? port_d.value : '0;
    result_o.channel_number = ok ? channel_d.value : '0;
    result_o.relay_on       = ok && (word_match_d == WM_ON);
  end

  // Hold state; clear it after the final byte of a line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_count_q  <= 2'd0;
      inside_token_q <= 1'b0;
      port_q         <= '{value: '0, scan: SCAN_NONE};
      channel_q      <= '{value: '0, scan: SCAN_NONE};
      word_match_q   <= WM_START;
    end else if (step_i) begin
      if (last_byte_i) begin
        token_count_q  <= 2'd0;
        inside_token_q <= 1'b0;
        port_q         <= '{value: '0, scan: SCAN_NONE};
        channel_q      <= '{value: '0, scan: SCAN_NONE};
        word_match_q   <= WM_START;
      end else begin
        token_count_q  <= token_count_d;
        inside_token_q <= inside_token_d;
        port_q         <= port_d;
        channel_q      <= channel_d;
        word_match_q   <= word_match_d;
      end
    end
  end

endmodule

// File: rtl/core/relay_command_line_parser_core.sv
// Channel  Dir  Payload
// in_i     in   data_byte[7:0], last_byte
// out_o    out  command_ok, port_number[4:0], channel_number[4:0], relay_on
//
// One byte per cycle sustained; a byte is parsed from the input register once taken,
// and the result of a line appears in the cycle after its final byte is parsed.
// A final byte passes the input register, then the result register, before its
// result appears. Reset clears parse state and both valid flags.
// A stalled result blocks only a final byte; other bytes keep flowing.
module relay_command_line_parser_core
  import rcl_pkg::*;
#(
  parameter int unsigned MAX_INDEX = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  rcl_in_if.sink    in_i,
  rcl_out_if.source out_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  result_t    out_res_q;
  result_t    parse_res;
  logic       advance;
  logic       take;

  // Parse the registered byte when its result, if any, has room
  assign advance = in_valid_q && (!in_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign take = in_i.valid && in_i.ready;

  rcl_parse #(
    .MAX_INDEX(MAX_INDEX)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .data_byte_i(in_byte_q),
    .last_byte_i(in_last_q),
    .result_o   (parse_res)
  );

  // Track valid flags for input and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (advance && in_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
    if (advance && in_last_q) out_res_q <= parse_res;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.command_ok     = out_res_q.command_ok;
  assign out_o.port_number    = out_res_q.port_number;
  assign out_o.channel_number = out_res_q.channel_number;
  assign out_o.relay_on       = out_res_q.relay_on;

endmodule

// File: tb/relay_command_line_parser_core_tb.sv
module relay_command_line_parser_core_tb;
  import rcl_pkg::*;

  localparam int unsigned MaxIndex = 16;
  localparam logic [7:0] ChrVt = 8'd11;
  localparam logic [7:0] ChrLf = 8'd10;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } line_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rcl_in_if  in_if();
  rcl_out_if out_if();

  relay_command_line_parser_core #(
    .MAX_INDEX(MaxIndex)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Sender and receiver registers, known from time zero
  logic       drv_valid = 1'b0;
  logic [7:0] drv_data = 8'd0;
  logic       drv_last = 1'b0;
  logic       mon_ready = 1'b0;

  assign in_if.valid     = drv_valid;
  assign in_if.data_byte = drv_data;
  assign in_if.last_byte = drv_last;
  assign out_if.ready    = mon_ready;

  // Byte queue for the sender, line under construction, expected commands
  line_byte_t  pending_bytes[$];
  logic [7:0]  line_buf[$];
  result_t     expected_cmds[$];

  int unsigned fail_cnt = 0;
  int unsigned bytes_built = 0;
  int unsigned lines_built = 0;
  int unsigned bytes_sent = 0;
  int unsigned cmds_ok = 0;
  int unsigned cmds_bad = 0;
  int unsigned results_seen = 0;

  // Parser state mirrored in the testbench
  logic [1:0] tok_cnt;
  logic       in_tok;
  logic [4:0] port_val;
  scan_e      port_scn;
  logic [4:0] chan_val;
  scan_e      chan_scn;
  match_e     word_st;

  initial forever #1 clk_i = ~clk_i;

  task automatic clear_parse();
    tok_cnt  = 2'd0;
    in_tok   = 1'b0;
    port_val = 5'd0;
    port_scn = SCAN_NONE;
    chan_val = 5'd0;
    chan_scn = SCAN_NONE;
    word_st  = WM_START;
  endtask

  // Extend one decimal run by a non-blank byte, saturating past MaxIndex
  task automatic scan_run(input logic [7:0] ch, inout logic [4:0] val, inout scan_e st);
    logic isdig;
    int   v;
    isdig = (ch >= 8'd48) && (ch <= 8'd57);
    if (st == SCAN_NONE) begin
      if (isdig) begin
        val = 5'(ch - 8'd48);
        st  = SCAN_RUN;
      end
    end else if (st == SCAN_RUN) begin
      if (isdig) begin
        v = int'(val) * 10 + int'(ch - 8'd48);
        if (v > MaxIndex + 1) v = MaxIndex + 1;
        val = 5'(v);
      end else begin
        st = SCAN_DONE;
      end
    end
  endtask

  // Advance the line parse by one byte; queue the command on the final byte
  task automatic parse_byte(input logic [7:0] ch, input logic fin);
    logic [7:0] lc;
    logic       ok;
    result_t    res;
    if (ch == 8'd32 || (ch >= 8'd9 && ch <= 8'd13)) begin
      in_tok = 1'b0;
      if (port_scn == SCAN_RUN) port_scn = SCAN_DONE;
      if (chan_scn == SCAN_RUN) chan_scn = SCAN_DONE;
    end else begin
      if (!in_tok) begin
        in_tok = 1'b1;
        if (tok_cnt != 2'd3) tok_cnt = tok_cnt + 2'd1;
        word_st = WM_START;
      end
      if (tok_cnt == 2'd1) scan_run(ch, port_val, port_scn);
      else scan_run(ch, chan_val, chan_scn);
      lc = (ch >= 8'd65 && ch <= 8'd90) ? ch + 8'd32 : ch;
      case (word_st)
        WM_START: word_st = (lc == 8'd111) ? WM_O : WM_DEAD;
        WM_O:     word_st = (lc == 8'd110) ? WM_ON : ((lc == 8'd102) ? WM_OF : WM_DEAD);
        WM_OF:    word_st = (lc == 8'd102) ? WM_OFF : WM_DEAD;
        default:  word_st = WM_DEAD;
      endcase
    end
    if (fin) begin
      ok = (tok_cnt == 2'd3) && (port_val >= 5'd1) && (port_val <= 5'(MaxIndex))
        && (chan_val >= 5'd1) && (chan_val <= 5'(MaxIndex))
        && (word_st == WM_ON || word_st == WM_OFF);
      res.command_ok     = ok;
      res.port_number    = ok ? port_val : 5'd0;
      res.channel_number = ok ? chan_val : 5'd0;
      res.relay_on       = ok && (word_st == WM_ON);
      expected_cmds.push_back(res);
      if (ok) cmds_ok++;
      else cmds_bad++;
      clear_parse();
    end
  endtask

  // Line construction helpers
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_blanks(input int lo, input int hi);
    int n;
    n = $urandom_range(hi, lo);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) line_buf.push_back(8'($urandom_range(13, 9)));
      else line_buf.push_back(ChrSpace);
    end
  endtask

  // Token bytes: neither blank nor digit, any value otherwise
  task automatic add_word(input int lo, input int hi);
    int         n;
    logic [7:0] ch;
    n = $urandom_range(hi, lo);
    repeat (n) begin
      ch = 8'($urandom_range(255, 0));
      while (ch == ChrSpace || (ch >= ChrTab && ch <= ChrCr) || (ch >= ChrZero && ch <= ChrNine))
        ch = 8'($urandom_range(255, 0));
      line_buf.push_back(ch);
    end
  endtask

  task automatic add_number();
    int v;
    case ($urandom_range(9, 0))
      0:       v = 0;
      1:       v = $urandom_range(1, 0) ? MaxIndex + 1 : $urandom_range(999, MaxIndex + 2);
      default: v = $urandom_range(MaxIndex, 1);
    endcase
    if ($urandom_range(4, 0) == 0) repeat ($urandom_range(2, 1)) add_text("0");
    add_text($sformatf("%0d", v));
  endtask

  // Status word in random letter case, now and then malformed
  task automatic add_status();
    string      w;
    logic [7:0] ch;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: w = "on";
      4, 5, 6, 7: w = "off";
      8:          w = "of";
      default: begin
        case ($urandom_range(4, 0))
          0:       w = "o";
          1:       w = "onn";
          2:       w = "offf";
          3:       w = "oof";
          default: w = "n";
        endcase
      end
    endcase
    for (int i = 0; i < w.len(); i++) begin
      ch = w[i];
      if ($urandom_range(1, 0)) ch = ch - 8'd32;
      line_buf.push_back(ch);
    end
  endtask

  // Hand the finished line to the sender, flagging its final byte
  task automatic push_line();
    line_byte_t it;
    while (line_buf.size() > 0) begin
      it.data = line_buf.pop_front();
      it.fin  = (line_buf.size() == 0);
      pending_bytes.push_back(it);
      bytes_built++;
    end
    lines_built++;
  endtask

  task automatic add_good_line();
    add_blanks(0, 2);
    if ($urandom_range(4, 0) == 0) add_word(1, 3);
    add_number();
    case ($urandom_range(9, 0))
      0: add_word(1, 2);
      1: begin
        add_word(1, 1);
        add_number();
      end
      default: ;
    endcase
    add_blanks(1, 3);
    if ($urandom_range(6, 0) == 0) begin
      add_word(1, 4);
      add_blanks(1, 2);
    end
    if ($urandom_range(9, 0) != 0) begin
      if ($urandom_range(9, 0) == 0) begin
        add_word(1, 3);
      end else begin
        if ($urandom_range(3, 0) == 0) add_word(1, 2);
        add_number();
      end
      add_blanks(1, 2);
    end
    add_status();
    if ($urandom_range(2, 0) == 0) add_blanks(1, 2);
  endtask

  // Noise: random bytes, blanks and digits with no structure
  task automatic add_noise_line();
    int n;
    n = $urandom_range(12, 1);
    repeat (n) begin
      case ($urandom_range(3, 0))
        0:       add_blanks(1, 1);
        1:       line_buf.push_back(8'($urandom_range(ChrNine, ChrZero)));
        default: line_buf.push_back(8'($urandom_range(255, 0)));
      endcase
    end
  endtask

  // Sender: bursts of random length separated by random gaps
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    line_byte_t nxt;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      drv_data  <= 8'd0;
      drv_last  <= 1'b0;
      gap_left = 0;
      burst_left = 0;
      clear_parse();
    end else begin
      if (drv_valid && in_if.ready) begin
        parse_byte(drv_data, drv_last);
        bytes_sent++;
      end
      if (!drv_valid || in_if.ready) begin
        if (gap_left > 0 || pending_bytes.size() == 0) begin
          if (gap_left > 0) gap_left--;
          drv_valid <= 1'b0;
        end else begin
          nxt = pending_bytes.pop_front();
          drv_valid <= 1'b1;
          drv_data  <= nxt.data;
          drv_last  <= nxt.fin;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(30, 0);
            gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(5, 1);
          end
        end
      end
    end
  end

  // Receiver: check each result, stall in random runs outside free stretches
  int stall_left = 0;
  logic [7:0] rx_cycle = 8'd0;

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      mon_ready <= 1'b0;
      stall_left = 0;
      rx_cycle = 8'd0;
    end else begin
      if (out_if.valid && mon_ready) begin
        results_seen++;
        if (expected_cmds.size() == 0) begin
          fail_cnt++;
          $display("%0t: result with none expected: ok=%0b port=%0d channel=%0d on=%0b",
                   $time, out_if.command_ok, out_if.port_number, out_if.channel_number,
                   out_if.relay_on);
        end else begin
          want = expected_cmds.pop_front();
          if (out_if.command_ok !== want.command_ok) begin
            fail_cnt++;
            $display("%0t: command_ok expected %0b got %0b",
                     $time, want.command_ok, out_if.command_ok);
          end
          if (out_if.port_number !== want.port_number) begin
            fail_cnt++;
            $display("%0t: port_number expected %0d got %0d",
                     $time, want.port_number, out_if.port_number);
          end
          if (out_if.channel_number !== want.channel_number) begin
            fail_cnt++;
            $display("%0t: channel_number expected %0d got %0d",
                     $time, want.channel_number, out_if.channel_number);
          end
          if (out_if.relay_on !== want.relay_on) begin
            fail_cnt++;
            $display("%0t: relay_on expected %0b got %0b",
                     $time, want.relay_on, out_if.relay_on);
          end
        end
      end
      rx_cycle = rx_cycle + 8'd1;
      if (stall_left > 0) begin
        stall_left--;
        mon_ready <= 1'b0;
      end else if (rx_cycle[7:6] == 2'd0) begin
        mon_ready <= 1'b1;
      end else if ($urandom_range(3, 0) == 0) begin
        stall_left = $urandom_range(8, 0);
        mon_ready <= 1'b0;
      end else begin
        mon_ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // Port 1, channel 16, tab separators, mixed-case on
    add_text("1");
    line_buf.push_back(ChrTab);
    add_text("16");
    line_buf.push_back(ChrTab);
    add_text("On");
    push_line();
    // Port 16, channel 1, vertical tab and carriage return, upper-case off
    add_text("16");
    line_buf.push_back(ChrVt);
    add_text("1");
    line_buf.push_back(ChrCr);
    add_text("OFF");
    push_line();
    // All-whitespace line
    line_buf.push_back(ChrLf);
    push_line();
    // Port one past the top of the range
    add_text("17 1 on");
    push_line();

    while (bytes_built < 650 || lines_built < 45) begin
      if ($urandom_range(9, 0) < 7) add_good_line();
      else add_noise_line();
      push_line();
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || drv_valid) @(posedge clk_i);
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d bytes in %0d lines with bursty input and stalled output",
             bytes_sent, lines_built);
    $display("%0d commands accepted, %0d rejected, %0d results checked",
             cmds_ok, cmds_bad, results_seen);
    if (fail_cnt == 0) begin
      $display("relay_command_line_parser_core: match");
    end else begin
      $display("relay_command_line_parser_core: mismatch");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #400000;
    $display("%0t: run did not finish in time", $time);
    $display("relay_command_line_parser_core: mismatch");
    $finish;
  end

endmodule
